// ----- hdl/smce_pkg.sv -----
package smce_pkg;

	// Input commands
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_COUNT = 2'd1;
	localparam logic [1:0] CMD_TROW  = 2'd2;
	localparam logic [1:0] CMD_QROW  = 2'd3;

	// Path ops
	localparam logic [1:0] OP_MATCH   = 2'd0;
	localparam logic [1:0] OP_DELETE  = 2'd1;
	localparam logic [1:0] OP_INSERT  = 2'd2;
	localparam logic [1:0] OP_INVALID = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_OP     = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;

	// Field widths and caps
	localparam int POS_W = 11;
	localparam int COL_W = 21;
	localparam logic [POS_W-1:0] POS_CAP = 11'd2047;
	localparam logic [COL_W-1:0] COL_CAP = 21'h1FFFFF;
	localparam logic [7:0] GAP_CHAR = 8'd45;

	// Controller states
	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_RDA   = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take_item;
		logic take_a;
		logic clear_regs;
		logic sweep;
		logic sel_ql;
		logic commit;
	} smce_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_clear;
		logic sweep_last;
	} smce_stat_t;

endpackage

// ----- hdl/smce_ram.sv -----
module smce_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- hdl/smce_ctrl.sv -----
module smce_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  smce_pkg::smce_stat_t stat,
	output smce_pkg::smce_cmd_t  cmd
);

	smce_pkg::state_t state_q, state_d;
	logic init_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != smce_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			smce_pkg::S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = init_q ? smce_pkg::S_IDLE : smce_pkg::S_DONE;
				end
			end
			smce_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (stat.is_clear) begin
						cmd.clear_regs = 1'b1;
						state_d = smce_pkg::S_CLEAR;
					end else begin
						state_d = smce_pkg::S_RDA;
					end
				end
			end
			smce_pkg::S_RDA: begin
				cmd.take_a  = 1'b1;
				cmd.sel_ql  = 1'b1;
				state_d     = smce_pkg::S_DONE;
			end
			smce_pkg::S_DONE: begin
				cmd.sel_ql = 1'b1;
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = smce_pkg::S_IDLE;
				end
			end
			default: state_d = smce_pkg::S_IDLE;
		endcase
	end

	// State, reset-sweep flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smce_pkg::S_CLEAR;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == smce_pkg::S_CLEAR && stat.sweep_last) begin
				init_q <= 1'b0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_rose_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == smce_pkg::S_DONE))
		else $error("result appeared outside commit");
	a_item_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smce_pkg::S_IDLE && in_valid && !stat.is_clear)
		|=> state_q == smce_pkg::S_RDA ##1 state_q == smce_pkg::S_DONE)
		else $error("item did not reach commit state");
	a_sweep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !cmd.commit && !cmd.take_item)
		else $error("sweep overlaps item handling");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smce_pkg::S_DONE && out_valid_q && out_stall)
		|=> state_q == smce_pkg::S_DONE)
		else $error("commit over a waiting result");
`endif

endmodule

// ----- hdl/smce_datapath.sv -----
module smce_datapath #(
	parameter int MAX_QUERY_LEN  = 1024,
	parameter int MAX_INSERT_RUN = 2047
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [10:0]          cfg_wr_data,
	input  logic [1:0]           cmd_in,
	input  logic [1:0]           op_in,
	input  logic [7:0]           residue_in,
	input  logic                 last_in,
	input  smce_pkg::smce_cmd_t  cmd,
	output smce_pkg::smce_stat_t stat,
	output logic [10:0]          lead_gaps,
	output logic [7:0]           symbol,
	output logic                 has_symbol,
	output logic [10:0]          trail_gaps,
	output logic [20:0]          col_count,
	output logic [1:0]           error,
	output logic                 row_end
);

	localparam int DEPTH = MAX_QUERY_LEN + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int RW = $clog2(MAX_INSERT_RUN + 1);
	localparam longint TOT_MAX = longint'(DEPTH) * longint'(MAX_INSERT_RUN);
	localparam int TW = $clog2(TOT_MAX + 1);
	localparam int SW = ((TW > smce_pkg::POS_W) ? TW : smce_pkg::POS_W) + 1;

	// Config and running state
	logic [10:0]               query_length_q;
	logic [smce_pkg::POS_W-1:0] pos_q;
	logic [RW-1:0]             run_q;
	logic [TW-1:0]             total_q;
	logic [AW-1:0]             cnt_q;

	// Latched item
	logic [1:0]    cmd_q;
	logic [1:0]    op_q;
	logic [7:0]    res_q;
	logic          last_q;
	logic [RW-1:0] a_q;

	// Table port
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [RW-1:0] wr_data;
	logic [AW-1:0] rd_addr;
	logic [RW-1:0] rd_data;

	// Commit logic
	logic [smce_pkg::POS_W-1:0] ql;
	logic                       pos_in;
	logic [smce_pkg::POS_W-1:0] pos_inc;
	logic [RW-1:0]              run_inc;
	logic [smce_pkg::POS_W-1:0] pos_d;
	logic [RW-1:0]              run_d;
	logic [TW-1:0]              total_d;
	logic                       tw_en;
	logic [AW-1:0]              tw_addr;
	logic [RW-1:0]              tw_data;
	logic [10:0]                lead_d;
	logic [7:0]                 sym_d;
	logic                       has_d;
	logic [10:0]                trail_d;
	logic [1:0]                 err_d;
	logic [SW-1:0]              cols;
	logic [20:0]                col_d;

	// Effective query length
	always_comb begin
		if (32'(query_length_q) > 32'(MAX_QUERY_LEN)) begin
			ql = smce_pkg::POS_W'(MAX_QUERY_LEN);
		end else begin
			ql = query_length_q;
		end
	end

	assign pos_in  = pos_q < ql;
	assign pos_inc = (pos_q != smce_pkg::POS_CAP) ? pos_q + 11'd1 : pos_q;
	assign run_inc = (run_q < RW'(MAX_INSERT_RUN)) ? run_q + RW'(1) : run_q;

	assign stat.is_clear   = (cmd_in == smce_pkg::CMD_CLEAR);
	assign stat.sweep_last = (cnt_q == AW'(MAX_QUERY_LEN));

	// Table read address: entry at position, then entry at query length
	assign rd_addr = cmd.sel_ql ? AW'(ql) : (pos_in ? AW'(pos_q) : '0);

	// Table write: clearing sweep or commit
	assign wr_en   = cmd.sweep || (cmd.commit && tw_en);
	assign wr_addr = cmd.sweep ? cnt_q : tw_addr;
	assign wr_data = cmd.sweep ? '0 : tw_data;

	smce_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Item result and state update; a_q is entry at position, rd_data at query length
	always_comb begin
		pos_d   = pos_q;
		run_d   = run_q;
		total_d = total_q;
		tw_en   = 1'b0;
		tw_addr = AW'(pos_q);
		tw_data = run_q;
		lead_d  = '0;
		sym_d   = '0;
		has_d   = 1'b0;
		trail_d = '0;
		err_d   = smce_pkg::ERR_NONE;
		priority if (cmd_q == smce_pkg::CMD_CLEAR) begin
			pos_d   = '0;
			run_d   = '0;
		end else if (cmd_q == smce_pkg::CMD_QROW) begin
			lead_d = pos_in ? 11'(a_q) : '0;
			sym_d  = res_q;
			has_d  = 1'b1;
			pos_d  = pos_inc;
			if (last_q) begin
				trail_d = 11'(rd_data);
				if (pos_inc != ql) err_d = smce_pkg::ERR_LENGTH;
			end
		end else if (op_q == smce_pkg::OP_INVALID) begin
			err_d = smce_pkg::ERR_OP;
		end else if (cmd_q == smce_pkg::CMD_COUNT) begin
			if (op_q == smce_pkg::OP_INSERT) begin
				run_d = run_inc;
				// trailing run raises the slot after the last position
				if (last_q && run_inc > rd_data) begin
					tw_en   = 1'b1;
					tw_addr = AW'(ql);
					tw_data = run_inc;
					total_d = total_q + TW'(run_inc - rd_data);
				end
			end else begin
				if (pos_in && run_q > a_q) begin
					tw_en   = 1'b1;
					total_d = total_q + TW'(run_q - a_q);
				end
				run_d = '0;
				pos_d = pos_inc;
			end
			if (last_q) begin
				if (pos_d != ql) err_d = smce_pkg::ERR_LENGTH;
			end
		end else begin
			has_d = 1'b1;
			if (op_q == smce_pkg::OP_INSERT) begin
				sym_d = res_q;
				run_d = run_inc;
			end else begin
				if (pos_in && a_q > run_q) lead_d = 11'(a_q - run_q);
				sym_d = (op_q == smce_pkg::OP_MATCH) ? res_q : smce_pkg::GAP_CHAR;
				run_d = '0;
				pos_d = pos_inc;
			end
			if (last_q) begin
				if (rd_data > run_d) trail_d = 11'(rd_data - run_d);
				if (pos_d != ql) err_d = smce_pkg::ERR_LENGTH;
			end
		end
		if (last_q) begin
			pos_d = '0;
			run_d = '0;
		end
	end

	// Column total, saturated
	assign cols  = SW'(total_d) + SW'(ql);
	assign col_d = (64'(cols) > 64'(smce_pkg::COL_CAP)) ? smce_pkg::COL_CAP : 21'(cols);

	// Control-side state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_length_q <= '0;
			pos_q          <= '0;
			run_q          <= '0;
			total_q        <= '0;
			cnt_q          <= '0;
		end else begin
			if (cfg_wr_en) query_length_q <= cfg_wr_data;
			if (cmd.clear_regs) begin
				pos_q   <= '0;
				run_q   <= '0;
				total_q <= '0;
			end else if (cmd.commit) begin
				pos_q   <= pos_d;
				run_q   <= run_d;
				total_q <= total_d;
			end
			if (cmd.sweep) begin
				cnt_q <= stat.sweep_last ? '0 : cnt_q + AW'(1);
			end
		end
	end

	// Item, first table read, result registers
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			cmd_q  <= cmd_in;
			op_q   <= op_in;
			res_q  <= residue_in;
			last_q <= last_in;
		end
		if (cmd.take_a) a_q <= rd_data;
		if (cmd.commit) begin
			lead_gaps  <= lead_d;
			symbol     <= sym_d;
			has_symbol <= has_d;
			trail_gaps <= trail_d;
			col_count  <= col_d;
			error      <= err_d;
			row_end    <= last_q;
		end
	end

endmodule

// ----- hdl/star_msa_column_expander_top.sv -----
// Star alignment column expander. One register (query_length) and one item
// channel; every item gives one result. Path, row and query items each go
// through a read of the insert table at the current query position, a
// read at the query-length slot, then the commit that updates the table and
// loads the output register. A clear item sweeps all MAX_QUERY_LEN+1 table
// entries and then commits its result. After reset the same sweep runs
// before the first item is accepted; configuration writes are taken during
// it. A finished result waits in the output register while the next item is
// accepted and read; that item's commit waits until the result is taken.
module star_msa_column_expander_top #(
	parameter int MAX_QUERY_LEN  = 1024,
	parameter int MAX_INSERT_RUN = 2047
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [1:0]  op,
	input  logic [7:0]  residue,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] lead_gaps,
	output logic [7:0]  symbol,
	output logic        has_symbol,
	output logic [10:0] trail_gaps,
	output logic [20:0] col_count,
	output logic [1:0]  error,
	output logic        row_end
);

	smce_pkg::smce_cmd_t  ctl;
	smce_pkg::smce_stat_t stat;

	smce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (ctl)
	);

	smce_datapath #(
		.MAX_QUERY_LEN (MAX_QUERY_LEN),
		.MAX_INSERT_RUN(MAX_INSERT_RUN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_in     (cmd),
		.op_in      (op),
		.residue_in (residue),
		.last_in    (last),
		.cmd        (ctl),
		.stat       (stat),
		.lead_gaps  (lead_gaps),
		.symbol     (symbol),
		.has_symbol (has_symbol),
		.trail_gaps (trail_gaps),
		.col_count  (col_count),
		.error      (error),
		.row_end    (row_end)
	);

endmodule
